>>> hdl/cdd_pkg.sv
// ----------------------------------------------------------------------------
// cdd_pkg
// Shared types, constants and the month table for the calendar day
// difference unit.
// ----------------------------------------------------------------------------
package cdd_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 12;
    localparam int COUNT_W = 20;

    // Day number from an epoch 400 years before year 0, max ~1.64M
    localparam int DNUM_W  = 21;
    localparam int YS_W    = 13;   // year plus epoch offset, max 4495

    localparam int MAX_YEAR    = 4095;
    localparam int COUNT_MAX   = (1 << COUNT_W) - 1;
    localparam int YEAR_OFFSET = 400;

    // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for x < 2^13
    localparam int RECIP_100   = 5243;
    localparam int RECIP_SHIFT = 19;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef struct packed {
        logic [DAY_W-1:0]   from_day;
        logic [MONTH_W-1:0] from_month;
        logic [YEAR_W-1:0]  from_year;
        logic [DAY_W-1:0]   to_day;
        logic [MONTH_W-1:0] to_month;
        logic [YEAR_W-1:0]  to_year;
    } t_in_item;

    typedef struct packed {
        logic [COUNT_W-1:0] day_count;
    } t_out_item;

    // What one lane hands to the merge stage
    typedef struct packed {
        logic [DNUM_W-1:0]  month_start;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_lane_res;

    function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [8:0] d;
        unique case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

>>> hdl/cdd_if.sv
// ----------------------------------------------------------------------------
// cdd_if
// Valid/ready channels for date pairs in and day counts out.
// ----------------------------------------------------------------------------
interface cdd_in_if;
    logic                valid;
    logic                ready;
    cdd_pkg::t_in_item   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cdd_out_if;
    logic                valid;
    logic                ready;
    cdd_pkg::t_out_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/cdd_lane.sv
// ----------------------------------------------------------------------------
// cdd_lane
// Converts one date into the day number of its month start. Two stages:
// reciprocal divides by 100, then the sum with the leap adjustment.
// ----------------------------------------------------------------------------
module cdd_lane (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [cdd_pkg::DAY_W-1:0]       i_day,
    input  logic [cdd_pkg::MONTH_W-1:0]     i_month,
    input  logic [cdd_pkg::YEAR_W-1:0]      i_year,
    output cdd_pkg::t_lane_res              o_res
);

    localparam int PROD_W = 2 * cdd_pkg::YS_W;

    logic [cdd_pkg::MONTH_W-1:0] m_fix;
    logic [cdd_pkg::YEAR_W-1:0]  y_fix;
    logic [cdd_pkg::YS_W-1:0]    ys;
    logic [cdd_pkg::YS_W-1:0]    n;
    logic [PROD_W-1:0]           prod_n;
    logic [PROD_W-1:0]           prod_q4;
    logic [PROD_W-1:0]           prod_y;

    logic [cdd_pkg::YEAR_W-1:0]  r_y;
    logic [cdd_pkg::MONTH_W-1:0] r_m;
    logic [cdd_pkg::DAY_W-1:0]   r_d;
    logic [cdd_pkg::YS_W-1:0]    r_ys;
    logic [6:0]                  r_q100;
    logic [4:0]                  r_q400;
    logic [5:0]                  r_qy;

    // stage A: clamp fields, divide by 100 through reciprocals
    always_comb begin
        if (i_month < cdd_pkg::MONTH_JAN) begin
            m_fix = cdd_pkg::MONTH_JAN;
        end else if (i_month > cdd_pkg::MONTH_DEC) begin
            m_fix = cdd_pkg::MONTH_DEC;
        end else begin
            m_fix = i_month;
        end
        if (32'(i_year) > 32'(cdd_pkg::MAX_YEAR)) begin
            y_fix = cdd_pkg::YEAR_W'(cdd_pkg::MAX_YEAR);
        end else begin
            y_fix = i_year;
        end
        ys      = cdd_pkg::YS_W'(y_fix) + cdd_pkg::YS_W'(cdd_pkg::YEAR_OFFSET);
        n       = ys - cdd_pkg::YS_W'(1);
        prod_n  = PROD_W'(n) * PROD_W'(cdd_pkg::RECIP_100);
        prod_q4 = PROD_W'(n[cdd_pkg::YS_W-1:2]) * PROD_W'(cdd_pkg::RECIP_100);
        prod_y  = PROD_W'(y_fix) * PROD_W'(cdd_pkg::RECIP_100);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y    <= y_fix;
            r_m    <= m_fix;
            r_d    <= i_day;
            r_ys   <= ys;
            r_q100 <= prod_n[cdd_pkg::RECIP_SHIFT +: 7];
            r_q400 <= prod_q4[cdd_pkg::RECIP_SHIFT +: 5];
            r_qy   <= prod_y[cdd_pkg::RECIP_SHIFT +: 6];
        end
    end

    // stage B: day number of the first of the month
    logic [cdd_pkg::YEAR_W-1:0] y_rem;
    logic [cdd_pkg::YS_W-1:0]   n_b;
    logic                       leap;
    logic [cdd_pkg::DNUM_W-1:0] dnum;
    cdd_pkg::t_lane_res         r_res;

    always_comb begin
        y_rem = r_y - cdd_pkg::YEAR_W'(r_qy) * cdd_pkg::YEAR_W'(100);
        leap  = ((r_y[1:0] == 2'b00) && (y_rem != '0))
              || ((y_rem == '0) && (r_qy[1:0] == 2'b00));
        n_b   = r_ys - cdd_pkg::YS_W'(1);
        dnum  = cdd_pkg::DNUM_W'(r_ys) * cdd_pkg::DNUM_W'(365)
              + cdd_pkg::DNUM_W'(n_b[cdd_pkg::YS_W-1:2])
              - cdd_pkg::DNUM_W'(r_q100)
              + cdd_pkg::DNUM_W'(r_q400)
              + cdd_pkg::DNUM_W'(cdd_pkg::days_before_month(r_m))
              + cdd_pkg::DNUM_W'(leap && (r_m > cdd_pkg::MONTH_FEB));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res.month_start <= dnum;
            r_res.year        <= r_y;
            r_res.month       <= r_m;
            r_res.day         <= r_d;
        end
    end

    assign o_res = r_res;

endmodule

>>> hdl/cdd_merge.sv
// ----------------------------------------------------------------------------
// cdd_merge
// Combines the two lane results: order test, difference and saturation.
// ----------------------------------------------------------------------------
module cdd_merge (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  cdd_pkg::t_lane_res            i_from,
    input  cdd_pkg::t_lane_res            i_to,
    output logic [cdd_pkg::COUNT_W-1:0]   o_count
);

    localparam int DIFF_W = cdd_pkg::DNUM_W + 2;

    logic                        later;
    logic signed [DIFF_W-1:0]    diff;
    logic [cdd_pkg::COUNT_W-1:0] count;
    logic [cdd_pkg::COUNT_W-1:0] r_count;

    always_comb begin
        later = {i_from.year, i_from.month, i_from.day}
              > {i_to.year, i_to.month, i_to.day};
        diff  = $signed(DIFF_W'(i_to.month_start)) - $signed(DIFF_W'(i_from.month_start))
              + $signed(DIFF_W'(i_to.day)) - $signed(DIFF_W'(i_from.day));
        if (later || diff < 0) begin
            count = '0;
        end else if (diff > $signed(DIFF_W'(cdd_pkg::COUNT_MAX))) begin
            count = cdd_pkg::COUNT_W'(cdd_pkg::COUNT_MAX);
        end else begin
            count = diff[cdd_pkg::COUNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_count <= count;
        end
    end

    assign o_count = r_count;

    a_later_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && later) |=> (o_count == '0))
        else $error("later start date gave a nonzero count");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(o_count))
        else $error("count changed while stalled");

endmodule

>>> hdl/calendar_day_difference_unit.sv
// ----------------------------------------------------------------------------
// calendar_day_difference_unit
// Days from a start date to an end date (Gregorian), 0 if start is later.
//
//   channel  dir  payload                                  transfer when
//   i_in     in   from/to day, month, year (42 bits)       valid & ready
//   o_out    out  day_count (20 bits)                      valid & ready
//
// One date pair per cycle unless o_out is held; two lane stages, then one merge stage.
// Each date converts in its own lane; the reciprocal multiplies set stage one.
// The whole pipe stalls together when o_out is held; i_in.ready drops then.
// Synchronous active-low reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
module calendar_day_difference_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cdd_in_if.sink      i_in,
    cdd_out_if.source   o_out
);

    logic               adv;
    logic               r_v1, r_v2, r_v3;
    logic               n_v1, n_v2, n_v3;
    cdd_pkg::t_lane_res lane_from;
    cdd_pkg::t_lane_res lane_to;

    assign adv = !r_v3 || o_out.ready;

    cdd_lane u_lane_from (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_day   (i_in.data.from_day),
        .i_month (i_in.data.from_month),
        .i_year  (i_in.data.from_year),
        .o_res   (lane_from)
    );

    cdd_lane u_lane_to (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_day   (i_in.data.to_day),
        .i_month (i_in.data.to_month),
        .i_year  (i_in.data.to_year),
        .o_res   (lane_to)
    );

    cdd_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_from  (lane_from),
        .i_to    (lane_to),
        .o_count (o_out.data.day_count)
    );

    always_comb begin
        n_v1 = adv ? i_in.valid : r_v1;
        n_v2 = adv ? r_v1 : r_v2;
        n_v3 = adv ? r_v2 : r_v3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
        end
    end

    assign i_in.ready  = adv;
    assign o_out.valid = r_v3;

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_v1)
        else $error("accepted item did not enter the pipe");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while output stalled");

    a_stall_keeps_stages: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !o_out.ready) |=> (r_v3 && r_v2 == $past(r_v2) && r_v1 == $past(r_v1)))
        else $error("pipe stage moved during stall");

endmodule
